[hdl/nrcc_pkg.sv]
package nrcc_pkg;

   // field and register widths
   localparam int SEG_W     = 13;
   localparam int SWP_W     = 9;
   localparam int TICK_W    = 16;
   localparam int ADV_W     = 16;
   localparam int WORD_W    = 32;
   localparam int DUP_W     = 8;
   localparam int SQ_W      = 2 * SEG_W;            // segment_size squared
   localparam int RCV_W     = ADV_W + SEG_W;        // receiver window in bytes
   localparam int SEGX_W    = SEG_W + 2;            // 3x and 4x segment_size
   localparam int SWB_W     = SWP_W + SEG_W;        // send window in bytes
   localparam int DIV_CNT_W = $clog2(SQ_W);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = TICK_W;

   // event codes
   localparam logic [1:0] MODE_ACK  = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_OPEN = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_WINDOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // reset values
   localparam logic [SEG_W-1:0]  SEG_RESET     = 13'd1024;
   localparam logic [SWP_W-1:0]  SWP_RESET     = 9'd32;
   localparam logic [TICK_W-1:0] TICKS_RESET   = 16'd30;
   localparam logic [WORD_W-1:0] THRESH_RESET  = 32'd65535;
   localparam logic [RCV_W-1:0]  RCV_RESET     = 29'd65535;
   localparam logic [SWP_W-1:0]  INIT_SEGMENTS = 9'd10;
   localparam logic [DUP_W-1:0]  DUP_MAX       = 8'd255;
   localparam logic [DUP_W-1:0]  DUP_TRIGGER   = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_EXEC,
      ST_DIVIDE,
      ST_GROW,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic exec;
      logic div_start;
      logic grow;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
      logic [WORD_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
   endfunction

endpackage

[hdl/nrcc_divider.sv]
module nrcc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [nrcc_pkg::SQ_W-1:0]        dividend,
   input  logic [nrcc_pkg::WORD_W-1:0]      divisor,
   output logic                             done,
   output logic [nrcc_pkg::SQ_W-1:0]        quotient
);

   logic [nrcc_pkg::WORD_W-1:0]    rem_ff,     rem_in;
   logic [nrcc_pkg::SQ_W-1:0]      shift_ff,   shift_in;
   logic [nrcc_pkg::WORD_W-1:0]    divisor_ff, divisor_in;
   logic [nrcc_pkg::DIV_CNT_W-1:0] count_ff,   count_in;
   logic                           running_ff, running_in;
   logic                           done_ff,    done_in;
   logic [nrcc_pkg::WORD_W:0]      trial;
   logic [nrcc_pkg::WORD_W:0]      diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial      = {rem_ff, shift_ff[nrcc_pkg::SQ_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         shift_in   = dividend;
         divisor_in = divisor;
         count_in   = nrcc_pkg::DIV_CNT_W'(nrcc_pkg::SQ_W - 1);
         running_in = 1'b1;
      end else if (running_ff) begin
         if (!diff[nrcc_pkg::WORD_W]) begin
            rem_in = diff[nrcc_pkg::WORD_W-1:0];
         end else begin
            rem_in = trial[nrcc_pkg::WORD_W-1:0];
         end
         shift_in = {shift_ff[nrcc_pkg::SQ_W-2:0], ~diff[nrcc_pkg::WORD_W]};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

[hdl/nrcc_datapath.sv]
module nrcc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  nrcc_pkg::cmd_type                  cmd,
   output nrcc_pkg::status_type               status,
   input  logic                               csr_write_enable,
   input  logic [nrcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nrcc_pkg::CSR_DAT_W-1:0]     csr_write_data,
   input  logic [1:0]                         req_mode,
   input  logic [nrcc_pkg::WORD_W-1:0]        req_ack_number,
   input  logic [nrcc_pkg::ADV_W-1:0]         req_advertised_window,
   input  logic [nrcc_pkg::WORD_W-1:0]        req_next_sequence,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [nrcc_pkg::WORD_W-1:0]        rsp_congestion_window,
   output logic [nrcc_pkg::WORD_W-1:0]        rsp_slow_start_threshold,
   output logic [nrcc_pkg::WORD_W-1:0]        rsp_allowed_window,
   output logic [nrcc_pkg::WORD_W-1:0]        rsp_base_sequence,
   output logic                               rsp_in_recovery,
   output logic                               rsp_retransmit,
   output logic [nrcc_pkg::WORD_W-1:0]        rsp_retransmit_sequence,
   output logic                               rsp_timed_out
);

   localparam int W = nrcc_pkg::WORD_W;

   // configuration
   logic [nrcc_pkg::SEG_W-1:0]  seg_ff;
   logic [nrcc_pkg::SWP_W-1:0]  swp_ff;
   logic [nrcc_pkg::TICK_W-1:0] ticks_ff;

   // captured beat
   logic [1:0]                  mode_ff;
   logic [W-1:0]                ack_ff;
   logic [nrcc_pkg::ADV_W-1:0]  adv_ff;
   logic [W-1:0]                nxt_ff;

   // products prepared ahead of the update
   logic [nrcc_pkg::RCV_W-1:0]  rcv_prod_ff;
   logic [nrcc_pkg::SEGX_W-1:0] seg3_ff;
   logic [nrcc_pkg::SEGX_W-1:0] seg4_ff;
   logic [nrcc_pkg::SWB_W-1:0]  open_win_ff;
   logic [nrcc_pkg::SWB_W-1:0]  send_win_ff;
   logic [nrcc_pkg::SQ_W-1:0]   seg_sq_ff;
   logic [nrcc_pkg::SWP_W-1:0]  init_segs;

   // connection state
   logic [W-1:0]                window_ff,     window_in;
   logic [W-1:0]                thresh_ff,     thresh_in;
   logic [nrcc_pkg::RCV_W-1:0]  rcv_win_ff,    rcv_win_in;
   logic [nrcc_pkg::DUP_W-1:0]  dup_ff,        dup_in;
   logic [W-1:0]                last_ack_ff,   last_ack_in;
   logic [W-1:0]                oldest_ff,     oldest_in;
   logic [W-1:0]                rec_point_ff,  rec_point_in;
   logic                        recovering_ff, recovering_in;
   logic [nrcc_pkg::TICK_W-1:0] elapsed_ff,    elapsed_in;

   // per-event flags
   logic                        rtx_ff,     rtx_in;
   logic [W-1:0]                rtx_seq_ff, rtx_seq_in;
   logic                        tmo_ff,     tmo_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                out_window_ff;
   logic [W-1:0]                out_thresh_ff;
   logic [W-1:0]                out_allowed_ff;
   logic [W-1:0]                out_base_ff;
   logic                        out_recovery_ff;
   logic                        out_rtx_ff;
   logic [W-1:0]                out_rtx_seq_ff;
   logic                        out_tmo_ff;

   logic                        ack_new;
   logic [nrcc_pkg::DUP_W-1:0]  dup_inc;
   logic [W-1:0]                halved;
   logic [W-1:0]                half_win;
   logic [W-1:0]                grow_inc;
   logic [W-1:0]                allowed;
   logic [W-1:0]                win_or_rcv;
   logic                        div_done;
   logic [nrcc_pkg::SQ_W-1:0]   quotient;

   nrcc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (seg_sq_ff),
      .divisor  (window_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= nrcc_pkg::SEG_RESET;
         swp_ff   <= nrcc_pkg::SWP_RESET;
         ticks_ff <= nrcc_pkg::TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            nrcc_pkg::CSR_SEGMENT_SIZE:  seg_ff   <= csr_write_data[nrcc_pkg::SEG_W-1:0];
            nrcc_pkg::CSR_SEND_WINDOW:   swp_ff   <= csr_write_data[nrcc_pkg::SWP_W-1:0];
            nrcc_pkg::CSR_TIMEOUT_TICKS: ticks_ff <= csr_write_data[nrcc_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   assign init_segs = (swp_ff < nrcc_pkg::INIT_SEGMENTS) ? swp_ff : nrcc_pkg::INIT_SEGMENTS;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         ack_ff  <= req_ack_number;
         adv_ff  <= req_advertised_window;
         nxt_ff  <= req_next_sequence;
      end
      if (cmd.prep) begin
         rcv_prod_ff <= nrcc_pkg::RCV_W'(adv_ff) * nrcc_pkg::RCV_W'(seg_ff);
         seg3_ff     <= nrcc_pkg::SEGX_W'({seg_ff, 1'b0}) + nrcc_pkg::SEGX_W'(seg_ff);
         seg4_ff     <= {seg_ff, 2'b00};
         open_win_ff <= nrcc_pkg::SWB_W'(init_segs) * nrcc_pkg::SWB_W'(seg_ff);
         send_win_ff <= nrcc_pkg::SWB_W'(swp_ff) * nrcc_pkg::SWB_W'(seg_ff);
         seg_sq_ff   <= nrcc_pkg::SQ_W'(seg_ff) * nrcc_pkg::SQ_W'(seg_ff);
      end
   end

   assign ack_new  = ack_ff > oldest_ff;
   assign dup_inc  = (dup_ff == nrcc_pkg::DUP_MAX) ? dup_ff : dup_ff + 1'b1;
   assign half_win = {1'b0, window_ff[W-1:1]};
   assign halved   = (half_win > W'(seg_ff)) ? half_win : W'(seg_ff);
   assign grow_inc = (quotient == '0) ? W'(1) : W'(quotient);

   always_comb begin
      status.need_div = (mode_ff == nrcc_pkg::MODE_ACK) && ack_new && !recovering_ff &&
                        (window_ff >= thresh_ff) && (window_ff != '0);
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      window_in     = window_ff;
      thresh_in     = thresh_ff;
      rcv_win_in    = rcv_win_ff;
      dup_in        = dup_ff;
      last_ack_in   = last_ack_ff;
      oldest_in     = oldest_ff;
      rec_point_in  = rec_point_ff;
      recovering_in = recovering_ff;
      elapsed_in    = elapsed_ff;
      rtx_in        = rtx_ff;
      rtx_seq_in    = rtx_seq_ff;
      tmo_in        = tmo_ff;
      if (cmd.exec) begin
         rtx_in     = 1'b0;
         rtx_seq_in = '0;
         tmo_in     = 1'b0;
         case (mode_ff)
            nrcc_pkg::MODE_ACK: begin
               rcv_win_in = rcv_prod_ff;
               if (ack_new) begin
                  if (recovering_ff) begin
                     if (ack_ff >= rec_point_ff) begin
                        recovering_in = 1'b0;
                        dup_in        = '0;
                        window_in     = thresh_ff;
                     end else begin
                        rtx_in     = 1'b1;
                        rtx_seq_in = ack_ff;
                     end
                  end else begin
                     dup_in = '0;
                     if (window_ff < thresh_ff) begin
                        window_in = nrcc_pkg::sat_add(window_ff, W'(seg_ff));
                     end else if (window_ff == '0) begin
                        window_in = W'(1);
                     end
                     // nonzero window at or above threshold waits for the divider
                  end
                  oldest_in   = ack_ff;
                  last_ack_in = ack_ff;
                  elapsed_in  = '0;
               end else if (ack_ff == last_ack_ff) begin
                  dup_in = dup_inc;
                  if (dup_inc == nrcc_pkg::DUP_TRIGGER) begin
                     rec_point_in  = nxt_ff;
                     recovering_in = 1'b1;
                     thresh_in     = halved;
                     window_in     = nrcc_pkg::sat_add(halved, W'(seg3_ff));
                     rtx_in        = 1'b1;
                     rtx_seq_in    = ack_ff;
                  end else if (dup_inc > nrcc_pkg::DUP_TRIGGER) begin
                     window_in = nrcc_pkg::sat_add(window_ff, W'(seg_ff));
                  end
               end
            end
            nrcc_pkg::MODE_TICK: begin
               if (nxt_ff == oldest_ff) begin
                  elapsed_in = '0;
               end else if (elapsed_ff >= ticks_ff) begin
                  thresh_in     = halved;
                  window_in     = W'(seg4_ff);
                  dup_in        = '0;
                  recovering_in = 1'b0;
                  elapsed_in    = '0;
                  rtx_in        = 1'b1;
                  rtx_seq_in    = oldest_ff;
                  tmo_in        = 1'b1;
               end else begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            nrcc_pkg::MODE_OPEN: begin
               oldest_in  = ack_ff;
               rcv_win_in = rcv_prod_ff;
               window_in  = W'(open_win_ff);
               elapsed_in = '0;
            end
            default: ;
         endcase
      end
      if (cmd.grow) begin
         window_in = nrcc_pkg::sat_add(window_ff, grow_inc);
      end
   end

   always_ff @(posedge clock) begin
      rtx_ff     <= rtx_in;
      rtx_seq_ff <= rtx_seq_in;
      tmo_ff     <= tmo_in;
      if (reset) begin
         window_ff     <= W'(nrcc_pkg::SEG_RESET);
         thresh_ff     <= nrcc_pkg::THRESH_RESET;
         rcv_win_ff    <= nrcc_pkg::RCV_RESET;
         dup_ff        <= '0;
         last_ack_ff   <= '0;
         oldest_ff     <= '0;
         rec_point_ff  <= '0;
         recovering_ff <= 1'b0;
         elapsed_ff    <= '0;
      end else begin
         window_ff     <= window_in;
         thresh_ff     <= thresh_in;
         rcv_win_ff    <= rcv_win_in;
         dup_ff        <= dup_in;
         last_ack_ff   <= last_ack_in;
         oldest_ff     <= oldest_in;
         rec_point_ff  <= rec_point_in;
         recovering_ff <= recovering_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   assign win_or_rcv = (window_ff < W'(rcv_win_ff)) ? window_ff : W'(rcv_win_ff);
   assign allowed    = (W'(send_win_ff) < win_or_rcv) ? W'(send_win_ff) : win_or_rcv;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.report) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.report) begin
         out_window_ff   <= window_ff;
         out_thresh_ff   <= thresh_ff;
         out_allowed_ff  <= allowed;
         out_base_ff     <= oldest_ff;
         out_recovery_ff <= recovering_ff;
         out_rtx_ff      <= rtx_ff;
         out_rtx_seq_ff  <= rtx_seq_ff;
         out_tmo_ff      <= tmo_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_congestion_window    = out_window_ff;
   assign rsp_slow_start_threshold = out_thresh_ff;
   assign rsp_allowed_window       = out_allowed_ff;
   assign rsp_base_sequence        = out_base_ff;
   assign rsp_in_recovery          = out_recovery_ff;
   assign rsp_retransmit           = out_rtx_ff;
   assign rsp_retransmit_sequence  = out_rtx_seq_ff;
   assign rsp_timed_out            = out_tmo_ff;

endmodule

[hdl/nrcc_ctrl.sv]
module nrcc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nrcc_pkg::status_type  status,
   output nrcc_pkg::cmd_type     cmd
);

   nrcc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nrcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = nrcc_pkg::ST_PREP;
            end
         end
         nrcc_pkg::ST_PREP: state_in = nrcc_pkg::ST_EXEC;
         nrcc_pkg::ST_EXEC: begin
            state_in = status.need_div ? nrcc_pkg::ST_DIVIDE : nrcc_pkg::ST_REPORT;
         end
         nrcc_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = nrcc_pkg::ST_GROW;
            end
         end
         nrcc_pkg::ST_GROW: state_in = nrcc_pkg::ST_REPORT;
         nrcc_pkg::ST_REPORT: begin
            if (status.out_free) begin
               state_in = nrcc_pkg::ST_IDLE;
            end
         end
         default: state_in = nrcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         nrcc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         nrcc_pkg::ST_PREP: cmd.prep = 1'b1;
         nrcc_pkg::ST_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.div_start = status.need_div;
         end
         nrcc_pkg::ST_DIVIDE: ;
         nrcc_pkg::ST_GROW:   cmd.grow = 1'b1;
         nrcc_pkg::ST_REPORT: cmd.report = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/newreno_congestion_window_controller_top.sv]
// NewReno congestion window controller, sender side. Each beat on the req_
// channel is one event (acknowledgment, timer tick, connection open, or the
// unused code, which only reports) and produces exactly one rsp_ beat with the
// window, threshold, allowed send window, base sequence and retransmit/timeout
// flags after the event. One event is in work at a time. Most events pass
// through accept, prepare products, update state and load the result register,
// and no new beat is taken until the event in work has left that last step. A
// new acknowledgment in congestion avoidance also takes a divide step and a grow
// step, because its window step segment_size^2/window comes from a serial
// restoring divider that produces one quotient bit per cycle over 26 quotient
// bits; the step is added once the divider reports that it has finished.
// The result register lets the next event be accepted while the previous
// result still waits on rsp_stall; that next event then holds in its report
// step until the waiting result is taken.
// Registers on the csr_ port: 0 segment_size, 1 send_window_packets,
// 2 timeout_ticks; write them only while no event is in work.
module newreno_congestion_window_controller_top (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_write_enable,
   input  logic [nrcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nrcc_pkg::CSR_DAT_W-1:0]  csr_write_data,
   // event beats
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [nrcc_pkg::WORD_W-1:0]     req_ack_number,
   input  logic [nrcc_pkg::ADV_W-1:0]      req_advertised_window,
   input  logic [nrcc_pkg::WORD_W-1:0]     req_next_sequence,
   // result beats
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [nrcc_pkg::WORD_W-1:0]     rsp_congestion_window,
   output logic [nrcc_pkg::WORD_W-1:0]     rsp_slow_start_threshold,
   output logic [nrcc_pkg::WORD_W-1:0]     rsp_allowed_window,
   output logic [nrcc_pkg::WORD_W-1:0]     rsp_base_sequence,
   output logic                            rsp_in_recovery,
   output logic                            rsp_retransmit,
   output logic [nrcc_pkg::WORD_W-1:0]     rsp_retransmit_sequence,
   output logic                            rsp_timed_out
);

   nrcc_pkg::cmd_type    cmd;
   nrcc_pkg::status_type status;

   // sequencer: capture, prepare products, update state, divide, grow, report
   nrcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // connection state, configuration, divider and result register
   nrcc_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_mode                 (req_mode),
      .req_ack_number           (req_ack_number),
      .req_advertised_window    (req_advertised_window),
      .req_next_sequence        (req_next_sequence),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_congestion_window    (rsp_congestion_window),
      .rsp_slow_start_threshold (rsp_slow_start_threshold),
      .rsp_allowed_window       (rsp_allowed_window),
      .rsp_base_sequence        (rsp_base_sequence),
      .rsp_in_recovery          (rsp_in_recovery),
      .rsp_retransmit           (rsp_retransmit),
      .rsp_retransmit_sequence  (rsp_retransmit_sequence),
      .rsp_timed_out            (rsp_timed_out)
   );

endmodule

[tb/newreno_congestion_window_controller_top_tb.sv]
module newreno_congestion_window_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // index 3 has no register behind it; a write there must change nothing
   localparam logic [nrcc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_EVENTS_PER_SETTING = 115;

   // one result beat as the controller should report it
   typedef struct packed {
      logic [nrcc_pkg::WORD_W-1:0] cwnd;
      logic [nrcc_pkg::WORD_W-1:0] ssthresh;
      logic [nrcc_pkg::WORD_W-1:0] allowed;
      logic [nrcc_pkg::WORD_W-1:0] base;
      logic                        recovery;
      logic                        rtx;
      logic [nrcc_pkg::WORD_W-1:0] rtx_seq;
      logic                        timeout;
   } window_report_type;

   // DUT ports; every input starts at a known value
   logic                           clock;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [nrcc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [nrcc_pkg::CSR_DAT_W-1:0] csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_mode = nrcc_pkg::MODE_NONE;
   logic [nrcc_pkg::WORD_W-1:0]    req_ack_number = '0;
   logic [nrcc_pkg::ADV_W-1:0]     req_advertised_window = '0;
   logic [nrcc_pkg::WORD_W-1:0]    req_next_sequence = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [nrcc_pkg::WORD_W-1:0]    rsp_congestion_window;
   logic [nrcc_pkg::WORD_W-1:0]    rsp_slow_start_threshold;
   logic [nrcc_pkg::WORD_W-1:0]    rsp_allowed_window;
   logic [nrcc_pkg::WORD_W-1:0]    rsp_base_sequence;
   logic                           rsp_in_recovery;
   logic                           rsp_retransmit;
   logic [nrcc_pkg::WORD_W-1:0]    rsp_retransmit_sequence;
   logic                           rsp_timed_out;

   // register copies and connection state of the predictor
   logic [nrcc_pkg::SEG_W-1:0]     seg_size;
   logic [nrcc_pkg::SWP_W-1:0]     send_segments;
   logic [nrcc_pkg::TICK_W-1:0]    timeout_limit;
   logic [nrcc_pkg::WORD_W-1:0]    cwnd;
   logic [nrcc_pkg::WORD_W-1:0]    ssthresh;
   logic [nrcc_pkg::WORD_W-1:0]    rcv_bytes;
   logic [nrcc_pkg::DUP_W-1:0]     dup_acks;
   logic [nrcc_pkg::WORD_W-1:0]    prev_ack;
   logic [nrcc_pkg::WORD_W-1:0]    snd_una;
   logic [nrcc_pkg::WORD_W-1:0]    recover_seq;
   logic                           recovery_active;
   logic [nrcc_pkg::TICK_W-1:0]    tick_count;

   // highest sequence the traffic generator pretends to have sent
   logic [nrcc_pkg::WORD_W-1:0]    send_high = '0;

   window_report_type    expected_reports[$];
   int                   send_idle_pct = 16;
   int                   rsp_stall_pct = 71;
   int unsigned          events_sent = 0;
   int unsigned          result_beats = 0;
   int unsigned          error_count = 0;

   newreno_congestion_window_controller_top u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // saturate products and sums at the top of the 32-bit range
   function automatic logic [nrcc_pkg::WORD_W-1:0] clamp_product(
         input logic [nrcc_pkg::WORD_W-1:0] a,
         input logic [nrcc_pkg::WORD_W-1:0] b);
      logic [2*nrcc_pkg::WORD_W-1:0] p;
      p = {{nrcc_pkg::WORD_W{1'b0}}, a} * {{nrcc_pkg::WORD_W{1'b0}}, b};
      return (p[2*nrcc_pkg::WORD_W-1:nrcc_pkg::WORD_W] != '0) ? '1
                                                              : p[nrcc_pkg::WORD_W-1:0];
   endfunction

   function automatic logic [nrcc_pkg::WORD_W-1:0] clamp_sum(
         input logic [nrcc_pkg::WORD_W-1:0] a,
         input logic [nrcc_pkg::WORD_W-1:0] b);
      logic [nrcc_pkg::WORD_W-1:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   // new threshold on loss: half the window, never below one segment
   function automatic logic [nrcc_pkg::WORD_W-1:0] halved_window();
      logic [nrcc_pkg::WORD_W-1:0] half;
      half = cwnd >> 1;
      return (half > nrcc_pkg::WORD_W'(seg_size)) ? half : nrcc_pkg::WORD_W'(seg_size);
   endfunction

   function automatic void clear_window_model();
      seg_size        = nrcc_pkg::SEG_RESET;
      send_segments   = nrcc_pkg::SWP_RESET;
      timeout_limit   = nrcc_pkg::TICKS_RESET;
      cwnd            = nrcc_pkg::WORD_W'(nrcc_pkg::SEG_RESET);
      ssthresh        = nrcc_pkg::THRESH_RESET;
      rcv_bytes       = nrcc_pkg::WORD_W'(nrcc_pkg::RCV_RESET);
      dup_acks        = '0;
      prev_ack        = '0;
      snd_una         = '0;
      recover_seq     = '0;
      recovery_active = 1'b0;
      tick_count      = '0;
   endfunction

   // advance the connection state by one event and return what it reports
   function automatic window_report_type predict_report(
         input logic [1:0]                  mode,
         input logic [nrcc_pkg::WORD_W-1:0] ack,
         input logic [nrcc_pkg::ADV_W-1:0]  adv,
         input logic [nrcc_pkg::WORD_W-1:0] nxt);
      window_report_type r;
      logic [nrcc_pkg::WORD_W-1:0] seg32;
      logic [nrcc_pkg::WORD_W-1:0] growth;
      logic [nrcc_pkg::WORD_W-1:0] send_bytes;
      logic [nrcc_pkg::WORD_W-1:0] init_segments;
      r = '0;
      seg32 = nrcc_pkg::WORD_W'(seg_size);
      case (mode)
         nrcc_pkg::MODE_ACK: begin
            rcv_bytes = clamp_product(nrcc_pkg::WORD_W'(adv), seg32);
            if (ack > snd_una) begin
               if (recovery_active) begin
                  if (ack >= recover_seq) begin
                     // full ack: leave recovery and deflate to the threshold
                     recovery_active = 1'b0;
                     dup_acks = '0;
                     cwnd = ssthresh;
                  end else begin
                     // partial ack: resend the next hole
                     r.rtx = 1'b1;
                     r.rtx_seq = ack;
                  end
               end else begin
                  dup_acks = '0;
                  if (cwnd < ssthresh) begin
                     cwnd = clamp_sum(cwnd, seg32);
                  end else begin
                     growth = 32'd1;
                     if (cwnd != '0) growth = (seg32 * seg32) / cwnd;
                     if (growth == '0) growth = 32'd1;
                     cwnd = clamp_sum(cwnd, growth);
                  end
               end
               snd_una = ack;
               prev_ack = ack;
               tick_count = '0;
            end else if (ack == prev_ack) begin
               if (dup_acks != nrcc_pkg::DUP_MAX) dup_acks = dup_acks + 1'b1;
               if (dup_acks == nrcc_pkg::DUP_TRIGGER) begin
                  recover_seq = nxt;
                  recovery_active = 1'b1;
                  ssthresh = halved_window();
                  cwnd = clamp_sum(ssthresh, clamp_product(32'd3, seg32));
                  r.rtx = 1'b1;
                  r.rtx_seq = ack;
               end else if (dup_acks > nrcc_pkg::DUP_TRIGGER) begin
                  cwnd = clamp_sum(cwnd, seg32);
               end
            end
         end
         nrcc_pkg::MODE_TICK: begin
            if (nxt == snd_una) begin
               tick_count = '0;
            end else if (tick_count >= timeout_limit) begin
               ssthresh = halved_window();
               cwnd = clamp_product(32'd4, seg32);
               dup_acks = '0;
               recovery_active = 1'b0;
               tick_count = '0;
               r.rtx = 1'b1;
               r.rtx_seq = snd_una;
               r.timeout = 1'b1;
            end else begin
               tick_count = tick_count + 1'b1;
            end
         end
         nrcc_pkg::MODE_OPEN: begin
            snd_una = ack;
            rcv_bytes = clamp_product(nrcc_pkg::WORD_W'(adv), seg32);
            init_segments = (send_segments < nrcc_pkg::INIT_SEGMENTS)
                            ? nrcc_pkg::WORD_W'(send_segments)
                            : nrcc_pkg::WORD_W'(nrcc_pkg::INIT_SEGMENTS);
            cwnd = clamp_product(init_segments, seg32);
            tick_count = '0;
         end
         default: ;
      endcase
      send_bytes = clamp_product(nrcc_pkg::WORD_W'(send_segments), seg32);
      r.cwnd     = cwnd;
      r.ssthresh = ssthresh;
      r.allowed  = send_bytes;
      if (cwnd < r.allowed) r.allowed = cwnd;
      if (rcv_bytes < r.allowed) r.allowed = rcv_bytes;
      r.base     = snd_una;
      r.recovery = recovery_active;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared driving and checking
   // ------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [nrcc_pkg::WORD_W-1:0] got,
                              input logic [nrcc_pkg::WORD_W-1:0] want);
      if (got !== want)
         report_error($sformatf("result beat %0d %s: got %h, expected %h",
                                result_beats, name, got, want));
   endtask

   // Send one event beat. Idle first at the current sender rate with junk on
   // the bus, then hold the payload until the block takes it, then predict.
   task automatic send_event(input logic [1:0]                  mode,
                             input logic [nrcc_pkg::WORD_W-1:0] ack,
                             input logic [nrcc_pkg::ADV_W-1:0]  adv,
                             input logic [nrcc_pkg::WORD_W-1:0] nxt);
      window_report_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid             <= 1'b0;
         req_mode              <= 2'($urandom);
         req_ack_number        <= $urandom;
         req_advertised_window <= nrcc_pkg::ADV_W'($urandom);
         req_next_sequence     <= $urandom;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_mode              <= mode;
      req_ack_number        <= ack;
      req_advertised_window <= adv;
      req_next_sequence     <= nxt;
      do @(posedge clock); while (req_stall);
      want = predict_report(mode, ack, adv, nxt);
      expected_reports.insert(expected_reports.size(), want);
      if (mode != nrcc_pkg::MODE_NONE) events_sent++;
   endtask

   // Drop valid and wait until every expected result is back; the block then
   // holds no event and registers may be written.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [nrcc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nrcc_pkg::CSR_DAT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         nrcc_pkg::CSR_SEGMENT_SIZE:  seg_size      = data[nrcc_pkg::SEG_W-1:0];
         nrcc_pkg::CSR_SEND_WINDOW:   send_segments = data[nrcc_pkg::SWP_W-1:0];
         nrcc_pkg::CSR_TIMEOUT_TICKS: timeout_limit = data[nrcc_pkg::TICK_W-1:0];
         default: ;
      endcase
   endtask

   // Check every result beat against the oldest prediction, then pick the
   // stall for the next cycle at the current receiver rate.
   always @(posedge clock) begin : check_results
      window_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            report_error($sformatf("result beat %0d arrived with nothing expected",
                                   result_beats));
         end else begin
            want = expected_reports.pop_front();
            check_field("congestion_window",    rsp_congestion_window,    want.cwnd);
            check_field("slow_start_threshold", rsp_slow_start_threshold, want.ssthresh);
            check_field("allowed_window",       rsp_allowed_window,       want.allowed);
            check_field("base_sequence",        rsp_base_sequence,        want.base);
            check_field("in_recovery",          nrcc_pkg::WORD_W'(rsp_in_recovery),
                        nrcc_pkg::WORD_W'(want.recovery));
            check_field("retransmit",           nrcc_pkg::WORD_W'(rsp_retransmit),
                        nrcc_pkg::WORD_W'(want.rtx));
            check_field("retransmit_sequence",  rsp_retransmit_sequence,  want.rtx_seq);
            check_field("timed_out",            nrcc_pkg::WORD_W'(rsp_timed_out),
                        nrcc_pkg::WORD_W'(want.timeout));
         end
         result_beats++;
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Report-only beats around the reset state, plus an ack at zero that
   // counts as a first duplicate of the reset acknowledgment.
   task automatic test_report_only();
      send_event(nrcc_pkg::MODE_NONE, $urandom, nrcc_pkg::ADV_W'($urandom), $urandom);
      send_event(nrcc_pkg::MODE_ACK, '0, '0, '0);
      send_event(nrcc_pkg::MODE_NONE, '1, '1, '1);
   endtask

   // Walk one connection through slow start, fast retransmit on the third
   // duplicate, window inflation, a partial ack, a full ack and then
   // congestion avoidance up to the top of the sequence space.
   task automatic test_fast_recovery();
      send_event(nrcc_pkg::MODE_OPEN, 32'd1000, '1, '1);
      send_event(nrcc_pkg::MODE_ACK, 32'd2024, '0, 32'd20000);
      repeat (3) send_event(nrcc_pkg::MODE_ACK, 32'd2024, 16'd40, 32'd20000);
      send_event(nrcc_pkg::MODE_ACK, 32'd2024, 16'd40, 32'd20000);
      send_event(nrcc_pkg::MODE_ACK, 32'd8000, 16'd40, 32'd20000);
      send_event(nrcc_pkg::MODE_ACK, 32'd20000, 16'd40, 32'd30000);
      send_event(nrcc_pkg::MODE_ACK, 32'd30000, 16'd40, 32'd30000);
      send_event(nrcc_pkg::MODE_ACK, '1, '1, '1);
   endtask

   // Count ticks only while data is outstanding; expire at the limit, and at
   // once when the limit is zero.
   task automatic test_timeout();
      wait_idle();
      write_reg(nrcc_pkg::CSR_TIMEOUT_TICKS, 16'd2);
      send_event(nrcc_pkg::MODE_OPEN, 32'd5000, 16'd100, 32'd5000);
      send_event(nrcc_pkg::MODE_TICK, '0, '0, 32'd5000);
      repeat (3) send_event(nrcc_pkg::MODE_TICK, '0, '0, 32'd8000);
      wait_idle();
      write_reg(nrcc_pkg::CSR_TIMEOUT_TICKS, 16'd0);
      send_event(nrcc_pkg::MODE_TICK, '0, '0, 32'd8000);
   endtask

   // With a zero segment size the window and threshold both drop to zero;
   // congestion avoidance must then still add one byte per new ack.
   task automatic test_zero_window();
      wait_idle();
      write_reg(nrcc_pkg::CSR_SEGMENT_SIZE, 16'd0);
      write_reg(nrcc_pkg::CSR_SEND_WINDOW, 16'd0);
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_event(nrcc_pkg::MODE_OPEN, 32'd100, 16'd7, 32'd200);
      send_event(nrcc_pkg::MODE_TICK, '0, '0, 32'd200);
      send_event(nrcc_pkg::MODE_ACK, 32'd150, 16'd7, 32'd200);
      send_event(nrcc_pkg::MODE_ACK, 32'd180, 16'd7, 32'd200);
   endtask

   function automatic logic [nrcc_pkg::ADV_W-1:0] pick_advertised();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return nrcc_pkg::ADV_W'($urandom);
         default: return nrcc_pkg::ADV_W'($urandom_range(1, 64));
      endcase
   endfunction

   // One random burst of traffic. Most bursts follow the connection: new
   // acks inside the data in flight, runs of duplicates, runs of ticks. The
   // rest are reopens, stale acks, unused codes and raw noise.
   task automatic random_burst();
      int unsigned pick;
      logic [nrcc_pkg::WORD_W-1:0] step;
      logic [nrcc_pkg::WORD_W-1:0] ack;
      pick = $urandom_range(99);
      step = (seg_size == '0) ? 32'd1 : nrcc_pkg::WORD_W'(seg_size);
      if ($urandom_range(2) == 0) send_high = send_high + step * $urandom_range(1, 4);
      if (pick < 3) begin
         ack = ($urandom_range(7) == 0) ? {16'hFFFF, 16'($urandom)}
                                        : nrcc_pkg::WORD_W'($urandom_range(0, 1 << 20));
         send_high = ack + step * $urandom_range(0, 8);
         send_event(nrcc_pkg::MODE_OPEN, ack, pick_advertised(), send_high);
      end else if (pick < 43) begin
         repeat ($urandom_range(1, 4)) begin
            if (send_high > snd_una) ack = snd_una + $urandom_range(1, send_high - snd_una);
            else ack = snd_una + step;
            send_event(nrcc_pkg::MODE_ACK, ack, pick_advertised(), send_high);
         end
      end else if (pick < 68) begin
         repeat ($urandom_range(1, 6))
            send_event(nrcc_pkg::MODE_ACK, prev_ack, pick_advertised(), send_high);
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 8))
            send_event(nrcc_pkg::MODE_TICK, $urandom, nrcc_pkg::ADV_W'($urandom),
                       ($urandom_range(3) == 0) ? snd_una : send_high);
      end else if (pick < 93) begin
         send_event(nrcc_pkg::MODE_ACK, snd_una - $urandom_range(0, 2 * step),
                    pick_advertised(), send_high);
      end else if (pick < 96) begin
         send_event(nrcc_pkg::MODE_NONE, $urandom, nrcc_pkg::ADV_W'($urandom), $urandom);
      end else begin
         send_event(2'($urandom), $urandom, nrcc_pkg::ADV_W'($urandom), $urandom);
      end
   endtask

   // Random traffic at one pair of idle rates, over three register settings:
   // ordinary values, everything at its widest, everything at one.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int unsigned quota;
      logic [nrcc_pkg::WORD_W-1:0] base;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int setting = 0; setting < 3; setting++) begin
         wait_idle();
         case (setting)
            0: begin
               write_reg(nrcc_pkg::CSR_SEGMENT_SIZE,
                         nrcc_pkg::CSR_DAT_W'($urandom_range(1, 4096)));
               write_reg(nrcc_pkg::CSR_SEND_WINDOW,
                         nrcc_pkg::CSR_DAT_W'($urandom_range(1, 256)));
               write_reg(nrcc_pkg::CSR_TIMEOUT_TICKS,
                         nrcc_pkg::CSR_DAT_W'($urandom_range(1, 6)));
            end
            1: begin
               write_reg(nrcc_pkg::CSR_SEGMENT_SIZE, '1);
               write_reg(nrcc_pkg::CSR_SEND_WINDOW, '1);
               write_reg(nrcc_pkg::CSR_TIMEOUT_TICKS, '1);
            end
            default: begin
               write_reg(nrcc_pkg::CSR_SEGMENT_SIZE, 16'd1);
               write_reg(nrcc_pkg::CSR_SEND_WINDOW, 16'd1);
               write_reg(nrcc_pkg::CSR_TIMEOUT_TICKS, 16'd1);
            end
         endcase
         quota = events_sent + RANDOM_EVENTS_PER_SETTING;
         base = nrcc_pkg::WORD_W'($urandom_range(0, 1 << 20));
         send_high = base;
         send_event(nrcc_pkg::MODE_OPEN, base, pick_advertised(), base);
         while (events_sent < quota) random_burst();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      clear_window_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_report_only();
      test_fast_recovery();
      test_timeout();
      test_zero_window();
      test_random_traffic(16, 71);
      test_random_traffic(71, 16);
      test_random_traffic(0, 0);
      wait_idle();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

endmodule
